/* design/rsag_pkg.sv */
// rsag_pkg: shared widths, register indexes, config and result types and the
// size clamp helper for the rotation sample address generator.
// No dependencies.
`timescale 1ns / 1ps

package rsag_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int STEP_BITS  = FRAC_BITS + 2;
    localparam int START_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 2;
    localparam int SIZE_BITS  = COORD_BITS + 1;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COS_STEP   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_STEP   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_X    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y    = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_WIDTH  = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_HEIGHT = CFG_INDEX_BITS'(5);
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_WIDTH  = CFG_INDEX_BITS'(6);
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_HEIGHT = CFG_INDEX_BITS'(7);

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {1'b1, {COORD_BITS{1'b0}}};
    localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRAC_BITS;

    // sizes are kept already clamped
    typedef struct packed {
        logic signed [STEP_BITS-1:0]  cos_step;
        logic signed [STEP_BITS-1:0]  sin_step;
        logic signed [START_BITS-1:0] start_x;
        logic signed [START_BITS-1:0] start_y;
        logic [SIZE_BITS-1:0]         src_width;
        logic [SIZE_BITS-1:0]         src_height;
        logic [SIZE_BITS-1:0]         out_width;
        logic [SIZE_BITS-1:0]         out_height;
    } cfg_t;

    typedef struct packed {
        logic                  frame_last;
        logic [COORD_BITS-1:0] out_y;
        logic [COORD_BITS-1:0] out_x;
        logic                  in_bounds;
        logic [COORD_BITS-1:0] src_y;
        logic [COORD_BITS-1:0] src_x;
    } result_t;

    // sizes above the coordinate range saturate; zero may stand for one
    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] s,
        input logic                 zero_is_one
    );
        logic [SIZE_BITS-1:0] r;
        if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end else if ((s == '0) && zero_is_one) begin
            r = SIZE_BITS'(1);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

/* design/rotation_sample_address_generator.sv */
// rotation_sample_address_generator: top level, ties config registers,
// raster walker and output skid stage. Depends on rsag_pkg, rsag_cfg_regs,
// rsag_walker and rsag_out_skid.
`timescale 1ns / 1ps

// Usage
//  s_ channel: one request per output pixel, in raster order; s_tdata[0] is
//   restart, which places that pixel at output (0,0) and loads the start
//   position. After the last pixel of a frame the walk wraps to (0,0) itself.
//  m_ channel: one result per request. m_tdata holds src_x, src_y, out_x,
//   out_y; m_tuser holds in_bounds (low means fill with the color key);
//   m_tlast marks the final pixel of the output frame.
//  cfg channel: register writes by index, always ready; writes are to be
//   taken only while idle, not enforced by the block. Steps and sizes act
//   at once, start_x/start_y at the next frame start. Results are registered.
//  Throughput: one pixel per cycle while s_tready is high; the walk update
//   is four 30-bit adds and four 13-bit compares side by side between the
//   walk registers and the output register.
//  Stall: a two-entry output stage keeps taking requests while the receiver
//   holds m_tready low, until both entries are full; s_tready is then low.
//  Reset: sync, active low; registers return to unit cos step, zero sin and
//   start, full-size images; the walk restarts at output (0,0), no results
//   are pending.
module rotation_sample_address_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rsag_pkg::IN_DATA_BITS-1:0]  s_tdata,   // [0] restart
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rsag_pkg::OUT_DATA_BITS-1:0] m_tdata,   // src_x, src_y, out_x, out_y
    output logic [0:0]                         m_tuser,   // in_bounds
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rsag_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rsag_pkg::*;

    cfg_t    cfg;
    result_t walk_result;
    result_t out_result;
    logic    accept;

    // only bit zero of the input word carries a field
    assign accept = s_tvalid && s_tready;

    rsag_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsag_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .restart (s_tdata[0]),
        .cfg     (cfg),
        .result  (walk_result)
    );

    rsag_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (walk_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // pack coordinates, zero-filled up to whole bytes
    assign m_tdata = OUT_DATA_BITS'({out_result.out_y, out_result.out_x,
                                     out_result.src_y, out_result.src_x});
    assign m_tuser = out_result.in_bounds;
    assign m_tlast = out_result.frame_last;

endmodule

/* design/rsag_cfg_regs.sv */
// rsag_cfg_regs: configuration register file, sizes stored clamped.
// Depends on rsag_pkg.
`timescale 1ns / 1ps

module rsag_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rsag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rsag_pkg::cfg_t                     cfg
);
    import rsag_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [SIZE_BITS-1:0] size_wr;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign size_wr   = cfg_data[SIZE_BITS-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_COS_STEP:   cfg_next.cos_step   = cfg_data[STEP_BITS-1:0];
                REG_SIN_STEP:   cfg_next.sin_step   = cfg_data[STEP_BITS-1:0];
                REG_START_X:    cfg_next.start_x    = cfg_data[START_BITS-1:0];
                REG_START_Y:    cfg_next.start_y    = cfg_data[START_BITS-1:0];
                REG_SRC_WIDTH:  cfg_next.src_width  = clamp_size(size_wr, 1'b0);
                REG_SRC_HEIGHT: cfg_next.src_height = clamp_size(size_wr, 1'b0);
                REG_OUT_WIDTH:  cfg_next.out_width  = clamp_size(size_wr, 1'b1);
                REG_OUT_HEIGHT: cfg_next.out_height = clamp_size(size_wr, 1'b1);
                default: ;  // unknown index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_step   <= STEP_ONE;
            cfg_reg.sin_step   <= '0;
            cfg_reg.start_x    <= '0;
            cfg_reg.start_y    <= '0;
            cfg_reg.src_width  <= SIZE_MAX;
            cfg_reg.src_height <= SIZE_MAX;
            cfg_reg.out_width  <= SIZE_MAX;
            cfg_reg.out_height <= SIZE_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/rsag_walker.sv */
// rsag_walker: raster walk state (row base, position, counters) and the
// per-pixel source coordinate and bounds logic. Depends on rsag_pkg.
`timescale 1ns / 1ps

module rsag_walker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              restart,
    input  rsag_pkg::cfg_t    cfg,
    output rsag_pkg::result_t result
);
    import rsag_pkg::*;

    logic [POS_BITS-1:0]   base_x_reg, base_y_reg, pos_x_reg, pos_y_reg;
    logic [POS_BITS-1:0]   base_x_next, base_y_next, pos_x_next, pos_y_next;
    logic [COORD_BITS-1:0] col_reg, row_reg, col_next, row_next;

    logic [POS_BITS-1:0]   start_x_ext, start_y_ext, cs_ext, sn_ext;
    logic [POS_BITS-1:0]   cur_bx, cur_by, cur_px, cur_py, row_bx, row_by;
    logic [COORD_BITS-1:0] cur_col, cur_row;
    logic [SIZE_BITS-1:0]  ip_x, ip_y;
    logic                  ok_x, ok_y, in_image, row_end, frame_end;

    assign start_x_ext = {{(POS_BITS-START_BITS){cfg.start_x[START_BITS-1]}}, cfg.start_x};
    assign start_y_ext = {{(POS_BITS-START_BITS){cfg.start_y[START_BITS-1]}}, cfg.start_y};
    assign cs_ext      = {{(POS_BITS-STEP_BITS){cfg.cos_step[STEP_BITS-1]}}, cfg.cos_step};
    assign sn_ext      = {{(POS_BITS-STEP_BITS){cfg.sin_step[STEP_BITS-1]}}, cfg.sin_step};

    // restart puts this pixel at the frame origin
    assign cur_bx  = restart ? start_x_ext : base_x_reg;
    assign cur_by  = restart ? start_y_ext : base_y_reg;
    assign cur_px  = restart ? start_x_ext : pos_x_reg;
    assign cur_py  = restart ? start_y_ext : pos_y_reg;
    assign cur_col = restart ? '0 : col_reg;
    assign cur_row = restart ? '0 : row_reg;

    // negative positions are always outside
    assign ip_x     = cur_px[POS_BITS-2:FRAC_BITS];
    assign ip_y     = cur_py[POS_BITS-2:FRAC_BITS];
    assign ok_x     = !cur_px[POS_BITS-1] && (ip_x < cfg.src_width);
    assign ok_y     = !cur_py[POS_BITS-1] && (ip_y < cfg.src_height);
    assign in_image = ok_x && ok_y;

    assign row_end   = ({1'b0, cur_col} + SIZE_BITS'(1)) >= cfg.out_width;
    assign frame_end = row_end && (({1'b0, cur_row} + SIZE_BITS'(1)) >= cfg.out_height);

    assign result.src_x      = in_image ? ip_x[COORD_BITS-1:0] : '0;
    assign result.src_y      = in_image ? ip_y[COORD_BITS-1:0] : '0;
    assign result.in_bounds  = in_image;
    assign result.out_x      = cur_col;
    assign result.out_y      = cur_row;
    assign result.frame_last = frame_end;

    // next row base: rotate the column step by a quarter turn
    assign row_bx = cur_bx - sn_ext;
    assign row_by = cur_by + cs_ext;

    always_comb begin
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (frame_end) begin
                base_x_next = start_x_ext;
                base_y_next = start_y_ext;
                pos_x_next  = start_x_ext;
                pos_y_next  = start_y_ext;
                col_next    = '0;
                row_next    = '0;
            end else if (row_end) begin
                base_x_next = row_bx;
                base_y_next = row_by;
                pos_x_next  = row_bx;
                pos_y_next  = row_by;
                col_next    = '0;
                row_next    = cur_row + COORD_BITS'(1);
            end else begin
                base_x_next = cur_bx;
                base_y_next = cur_by;
                pos_x_next  = cur_px + cs_ext;
                pos_y_next  = cur_py + sn_ext;
                col_next    = cur_col + COORD_BITS'(1);
                row_next    = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

`ifndef SYNTH
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters not cleared after last pixel of frame");
    a_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && row_end && !frame_end |=>
            (pos_x_reg == base_x_reg) && (pos_y_reg == base_y_reg) && (col_reg == '0))
        else $error("new row does not start at its row base");
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !in_image |-> (result.src_x == '0) && (result.src_y == '0))
        else $error("out of bounds pixel carries a nonzero source address");
`endif

endmodule

/* design/rsag_out_skid.sv */
// rsag_out_skid: two-entry output register and skid stage for result items.
// Depends on rsag_pkg.
`timescale 1ns / 1ps

module rsag_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsag_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rsag_pkg::result_t out_data
);
    import rsag_pkg::*;

    result_t main_data_reg, skid_data_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    push, pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= in_data;
            end else begin
                main_data_reg <= in_data;
            end
        end
    end

`ifndef SYNTH
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        push && main_valid_reg && !pop |=> skid_valid_reg && (skid_data_reg == $past(in_data)))
        else $error("request taken during stall not parked in skid entry");
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && pop |=> main_valid_reg && (main_data_reg == $past(skid_data_reg)))
        else $error("skid entry lost when output drained");
`endif

endmodule
